/* hw/rtl/receive_reorder_buffer_core_macros.svh */
// Assertion macros for the receive reorder buffer core.
`ifndef RECEIVE_REORDER_BUFFER_CORE_MACROS_SVH
`define RECEIVE_REORDER_BUFFER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define RRB_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rrb check failed");
`define RRB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rrb check failed");
`else
`define RRB_ASSERT_IMPLY(label, ante, cons)
`define RRB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/rrb_pkg.sv */
// Shared types and constants of the receive reorder buffer.
package rrb_pkg;

   localparam int QUEUE_AW = 1;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_DROP    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [31:0] seq;
      logic        fin;
      logic [31:0] pay;
   } frame_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] seq;
      logic [31:0] pay;
      logic        done;
      logic        last;
   } result_type;

endpackage

/* hw/rtl/rrb_front.sv */
// Front end: accepts frames into a two-entry queue for the back end.
module rrb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  rrb_pkg::frame_type req_frame,
   output logic               head_valid,
   output rrb_pkg::frame_type head_frame,
   input  logic               head_pop
);
   import rrb_pkg::*;

   localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

   frame_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign req_tready = (count_ff != FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_frame = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (QUEUE_AW + 1)'(1);
         2'b01:   count_in = count_ff - (QUEUE_AW + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_frame;
      end
   end

endmodule

/* hw/rtl/rrb_back.sv */
// Back end: classifies queued frames, stores, drains and emits results.
`include "receive_reorder_buffer_core_macros.svh"
module rrb_back #(
   parameter int WINDOW = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  rrb_pkg::frame_type  head_frame,
   output logic                head_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output rrb_pkg::result_type rsp_result
);
   import rrb_pkg::*;

   localparam int SW = $clog2(WINDOW);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_DRAIN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       last_ff, last_in;
   logic [SW-1:0]     last_slot_ff, last_slot_in;
   logic              done_ff, done_in;
   logic [31:0]       cur_seq_ff, cur_seq_in;
   logic [WINDOW-1:0] slot_valid_ff, slot_valid_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;

   logic [32:0]       slot_mem [WINDOW];
   logic [32:0]       rd_data_ff;
   logic [SW-1:0]     rd_addr;
   logic              mem_we;
   logic [SW-1:0]     mem_wa;

   logic              out_free;
   logic              out_load;
   logic [SW-1:0]     slot_p1;
   logic [31:0]       seq_gap;
   logic [SW:0]       slot_sum;
   logic [SW:0]       slot_wrap;
   logic              is_dup;
   logic              beyond;
   logic              in_order;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign slot_p1   = (last_slot_ff == SW'(WINDOW - 1)) ? '0 : last_slot_ff + SW'(1);
   assign rd_addr   = (last_slot_in == SW'(WINDOW - 1)) ? '0 : last_slot_in + SW'(1);
   assign seq_gap   = head_frame.seq - last_ff;
   assign slot_sum  = {1'b0, last_slot_ff} + seq_gap[SW:0];
   assign slot_wrap = (slot_sum >= (SW + 1)'(WINDOW)) ? slot_sum - (SW + 1)'(WINDOW)
                                                      : slot_sum;
   assign mem_wa    = slot_wrap[SW-1:0];
   assign is_dup    = (head_frame.seq <= last_ff);
   assign beyond    = (seq_gap > 32'(WINDOW));
   assign in_order  = (seq_gap == 32'd1);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      last_slot_in  = last_slot_ff;
      done_in       = done_ff;
      cur_seq_in    = cur_seq_ff;
      slot_valid_in = slot_valid_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      out_load      = 1'b0;
      head_pop      = 1'b0;
      mem_we        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (head_valid && out_free) begin
               head_pop     = 1'b1;
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               out_in.kind  = KIND_ACK;
               out_in.seq   = head_frame.seq;
               out_in.pay   = '0;
               out_in.done  = done_ff;
               out_in.last  = 1'b1;
               if (is_dup) begin
                  out_in.kind = KIND_ACK;
               end else if (done_ff || beyond) begin
                  out_in.kind = KIND_DROP;
               end else if (in_order) begin
                  last_in                = head_frame.seq;
                  last_slot_in           = slot_p1;
                  slot_valid_in[slot_p1] = 1'b0;
                  done_in                = head_frame.fin;
                  cur_seq_in             = head_frame.seq;
                  out_in.kind            = KIND_DELIVER;
                  out_in.pay             = head_frame.pay;
                  out_in.done            = head_frame.fin;
                  out_in.last            = 1'b0;
                  state_in               = S_DRAIN;
               end else begin
                  mem_we                = 1'b1;
                  slot_valid_in[mem_wa] = 1'b1;
               end
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               if (!done_ff && (last_ff != SEQ_MAX) && slot_valid_ff[slot_p1]) begin
                  last_in                = last_ff + 32'd1;
                  last_slot_in           = slot_p1;
                  slot_valid_in[slot_p1] = 1'b0;
                  done_in                = rd_data_ff[32];
                  out_in.kind            = KIND_DELIVER;
                  out_in.seq             = last_ff + 32'd1;
                  out_in.pay             = rd_data_ff[31:0];
                  out_in.done            = rd_data_ff[32];
                  out_in.last            = 1'b0;
               end else begin
                  out_in.kind = KIND_ACK;
                  out_in.seq  = cur_seq_ff;
                  out_in.pay  = '0;
                  out_in.done = done_ff;
                  out_in.last = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_ff       <= '0;
         last_slot_ff  <= '0;
         done_ff       <= 1'b0;
         slot_valid_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         last_slot_ff  <= last_slot_in;
         done_ff       <= done_in;
         slot_valid_ff <= slot_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_seq_ff <= cur_seq_in;
      out_ff     <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= {head_frame.fin, head_frame.pay};
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   `RRB_ASSERT_NEXT(a_drain_ends_after_done,
      (state_ff == S_DRAIN) && done_ff && out_free,
      (out_ff.kind == KIND_ACK) && out_ff.last)
   `RRB_ASSERT_NEXT(a_deliver_advances_last,
      out_load && (out_in.kind == KIND_DELIVER),
      last_ff == $past(out_in.seq))
   `RRB_ASSERT_NEXT(a_done_freezes_last, done_ff, $stable(last_ff))
   `RRB_ASSERT_IMPLY(a_idle_no_pending_next,
      (state_ff == S_IDLE) && !done_ff && (last_ff != SEQ_MAX),
      !slot_valid_ff[slot_p1])

endmodule

/* hw/rtl/receive_reorder_buffer_core.sv */
// Receive reorder buffer top level: stream ports around front queue and back end.
//
// Input channel req_*: one received frame per transfer. req_tdata carries the
// sequence number and payload descriptor, req_tlast the last-frame mark.
// Result channel rsp_*: one result per transfer. rsp_tuser gives the kind
// (deliver, acknowledge, drop), rsp_tlast marks the last result of a frame.
// A frame in order is delivered, then stored frames that follow are drained
// in order, then the frame is acknowledged; other frames give one result.
// Accepted frames wait in a two-entry queue. The back end loads one result
// per cycle into its output register while that register is free (empty or
// taken by the receiver); a frame passes through its queue entry and then the
// output register on its way to rsp_*.
// Stored frames sit in a WINDOW-entry slot memory with one registered read
// port, which supplies one drained frame per cycle while the output is free.
// Reset clears the expected sequence, the done flag, the slot valid bits, the
// queue and the output valid flag. When the receiver stalls, the output register
// holds its result, the back end waits, the queue fills and req_tready falls.
module receive_reorder_buffer_core #(
   parameter int WINDOW = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] seq_num, [63:32] payload_tag
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] out_seq, [63:32] out_payload,
                                    // [64] transfer_done, [71:65] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);
   import rrb_pkg::*;

   frame_type  req_frame;
   frame_type  head_frame;
   logic       head_valid;
   logic       head_pop;
   result_type rsp_result;

   assign req_frame.seq = req_tdata[31:0];
   assign req_frame.fin = req_tlast;
   assign req_frame.pay = req_tdata[63:32];

   rrb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_frame  (req_frame),
      .head_valid (head_valid),
      .head_frame (head_frame),
      .head_pop   (head_pop)
   );

   rrb_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_frame (head_frame),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {7'b0, rsp_result.done, rsp_result.pay, rsp_result.seq};
   assign rsp_tuser = rsp_result.kind;
   assign rsp_tlast = rsp_result.last;

endmodule

/* tb/sv/receive_reorder_buffer_checker.sv */
`timescale 1ns / 100ps
// Checker for the receive reorder buffer: predicts each frame's results and compares transfers.
module receive_reorder_buffer_checker #(
   parameter int WINDOW = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending,
   output int          frame_count,
   output int          deliver_count,
   output int          ack_count,
   output int          drop_count,
   output int          longest_run
);
   import rrb_pkg::*;

   logic [31:0] delivered_seq;
   logic        transfer_over;
   logic        slot_full [WINDOW];
   logic [31:0] slot_tag [WINDOW];
   logic        slot_last [WINDOW];
   result_type  due_results [$];

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t: rsp %s got %h, want %h", $time, field, got, want);
      end
   endtask

   function automatic result_type make_result(input kind_type kind, input logic [31:0] seq,
                                              input logic [31:0] tag);
      result_type r;
      r.kind = kind;
      r.seq  = seq;
      r.pay  = tag;
      r.done = transfer_over;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic reorder_frame(input logic [31:0] seq, input logic fin, input logic [31:0] tag);
      result_type  run [$];
      result_type  r;
      logic [32:0] gap;
      logic [31:0] nxt;
      int unsigned idx;
      if (seq <= delivered_seq) begin
         run.insert(run.size(), make_result(KIND_ACK, seq, '0));
      end else if (transfer_over) begin
         run.insert(run.size(), make_result(KIND_DROP, seq, '0));
      end else begin
         gap = {1'b0, seq} - {1'b0, delivered_seq};
         idx = seq % WINDOW;
         if (gap > WINDOW) begin
            run.insert(run.size(), make_result(KIND_DROP, seq, '0));
         end else if (gap == 1) begin
            slot_full[idx] = 1'b0;
            delivered_seq  = seq;
            if (fin) transfer_over = 1'b1;
            run.insert(run.size(), make_result(KIND_DELIVER, seq, tag));
            while (!transfer_over && delivered_seq != SEQ_MAX) begin
               nxt = delivered_seq + 32'd1;
               idx = nxt % WINDOW;
               if (!slot_full[idx]) break;
               slot_full[idx] = 1'b0;
               delivered_seq  = nxt;
               if (slot_last[idx]) transfer_over = 1'b1;
               run.insert(run.size(), make_result(KIND_DELIVER, nxt, slot_tag[idx]));
            end
            run.insert(run.size(), make_result(KIND_ACK, seq, '0));
         end else begin
            slot_full[idx] = 1'b1;
            slot_tag[idx]  = tag;
            slot_last[idx] = fin;
            run.insert(run.size(), make_result(KIND_ACK, seq, '0));
         end
      end
      if (run.size() > longest_run) longest_run = run.size();
      foreach (run[i]) begin
         r = run[i];
         r.last = (i == run.size() - 1);
         case (r.kind)
            KIND_DELIVER: deliver_count++;
            KIND_ACK:     ack_count++;
            default:      drop_count++;
         endcase
         due_results.insert(due_results.size(), r);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         delivered_seq = '0;
         transfer_over = 1'b0;
         foreach (slot_full[i]) slot_full[i] = 1'b0;
         due_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_mismatch("unexpected transfer, seq", rsp_tdata[31:0], '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("kind", 32'(rsp_tuser), 32'(want.kind));
               if (rsp_tdata[31:0] !== want.seq)
                  report_mismatch("out_seq", rsp_tdata[31:0], want.seq);
               if (rsp_tdata[63:32] !== want.pay)
                  report_mismatch("out_payload", rsp_tdata[63:32], want.pay);
               if (rsp_tdata[64] !== want.done)
                  report_mismatch("transfer_done", 32'(rsp_tdata[64]), 32'(want.done));
               if (rsp_tlast !== want.last)
                  report_mismatch("run_end", 32'(rsp_tlast), 32'(want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            frame_count++;
            reorder_frame(req_tdata[31:0], req_tlast, req_tdata[63:32]);
         end
      end
      pending = due_results.size();
   end

endmodule

/* tb/sv/tb_receive_reorder_buffer_core.sv */
`timescale 1ns / 100ps
// Testbench top for the receive reorder buffer core: clock, reset, frame stimulus and verdict.
module tb_receive_reorder_buffer_core;
   import rrb_pkg::*;

   localparam int WINDOW      = 8;
   localparam int ITEM_TARGET = 460;
   localparam int IDLE_LIMIT  = 4000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        steady     = 1'b0;

   int fail_count, pending, frame_count, deliver_count, ack_count, drop_count, longest_run;
   int quiet_cycles = 0;
   int sent = 0;

   always #6 clock = ~clock;

   receive_reorder_buffer_core #(.WINDOW(WINDOW)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   receive_reorder_buffer_checker #(.WINDOW(WINDOW)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending       (pending),
      .frame_count   (frame_count),
      .deliver_count (deliver_count),
      .ack_count     (ack_count),
      .drop_count    (drop_count),
      .longest_run   (longest_run)
   );

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("receive_reorder_buffer_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_frame(input logic [31:0] seq, input logic fin, input logic [31:0] tag);
      while (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tag, seq};
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic wait_for_results;
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // duplicates, far-off frames and random sequence numbers
   task automatic send_noise(input logic [31:0] base);
      case ($urandom_range(2))
         0: send_frame($urandom_range(base - 1, 0), 1'($urandom_range(1)), $urandom);
         1: send_frame(base + 16 + $urandom_range(200), 1'($urandom_range(1)), $urandom);
         default: send_frame($urandom, 1'($urandom_range(1)), $urandom);
      endcase
   endtask

   initial begin
      logic [31:0] base;
      logic [31:0] order [8];
      logic [31:0] swap;
      int          k;
      int          j;
      logic        paused;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_frame(32'd1, 1'b0, 32'h0000_0000);
      send_frame(32'd0, 1'b1, 32'hFFFF_FFFF);
      send_frame(32'd1, 1'b0, $urandom);
      send_frame(32'd10, 1'b0, $urandom);
      send_frame(32'hFFFF_FFFF, 1'b1, $urandom);
      send_frame(32'd9, 1'b0, $urandom);
      for (int s = 8; s >= 3; s--) send_frame(s, 1'b0, $urandom);
      send_frame(32'd5, 1'b0, $urandom);
      send_frame(32'd2, 1'b0, 32'hFFFF_FFFF);
      send_frame(32'd11, 1'b0, $urandom);
      send_frame(32'd10, 1'b0, $urandom);
      base = 32'd12;

      while (sent < ITEM_TARGET - 28) begin
         steady = (sent >= 250 && sent < 330);
         k = $urandom_range(WINDOW, 1);
         for (int i = 0; i < k; i++) order[i] = base + i;
         for (int i = k - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
         end
         for (int i = 0; i < k; i++) begin
            if ($urandom_range(99) < 10) send_noise(base);
            send_frame(order[i], 1'b0, $urandom);
            if ($urandom_range(99) < 8) send_frame(order[$urandom_range(i, 0)], 1'b0, $urandom);
         end
         base = base + k;
         if (sent >= 200 && !paused) begin
            paused = 1'b1;
            wait_for_results;
         end
      end
      steady = 1'b0;

      // final frame drains from its slot, two stored frames stay behind
      send_frame(base + 7, 1'b0, $urandom);
      send_frame(base + 6, 1'b0, $urandom);
      send_frame(base + 5, 1'b1, $urandom);
      send_frame(base + 3, 1'b0, $urandom);
      send_frame(base + 4, 1'b0, $urandom);
      send_frame(base + 1, 1'b0, $urandom);
      send_frame(base + 2, 1'b0, $urandom);
      send_frame(base, 1'b0, $urandom);
      repeat (12) begin
         if ($urandom_range(1))
            send_frame($urandom_range(base + 5, 0), 1'($urandom_range(1)), $urandom);
         else
            send_frame(base + 6 + $urandom_range(3), 1'($urandom_range(1)), $urandom);
      end

      wait_for_results;
      repeat (16) @(negedge clock);
      $display("frames %0d: %0d deliveries, %0d acks, %0d drops, up to %0d results per frame",
               frame_count, deliver_count, ack_count, drop_count, longest_run);
      $display("reordered window runs, duplicates, overwrites, far frames, final frame and after");
      if (fail_count == 0 && pending == 0) begin
         $display("receive_reorder_buffer_core: match");
      end else begin
         $display("receive_reorder_buffer_core: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rrb_pkg.sv
hw/rtl/rrb_front.sv
hw/rtl/rrb_back.sv
hw/rtl/receive_reorder_buffer_core.sv
tb/sv/receive_reorder_buffer_checker.sv
tb/sv/tb_receive_reorder_buffer_core.sv
